[rtl/core/x86ctu_pkg.sv]
// Shared types and constants for the x86 call target unfilter.
package x86ctu_pkg;

	// Scan phases of the front end
	typedef enum logic [1:0] {
		PH_SCAN    = 2'd0,
		PH_PREFIX  = 2'd1,
		PH_AWAIT   = 2'd2,
		PH_CAPTURE = 2'd3
	} phase_t;

	// Configuration register indexes
	localparam logic [1:0] REG_MARKER = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;
	localparam logic [1:0] REG_JCC    = 2'd2;

	// Opcode bytes
	localparam logic [7:0] OP_PREFIX = 8'h0F;
	localparam logic [7:0] OP_CALL   = 8'hE8;
	localparam logic [7:0] OP_JMP    = 8'hE9;
	localparam logic [7:0] OP_JCC_LO = 8'h80;
	localparam logic [7:0] OP_JCC_HI = 8'h8F;

	// Job queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// One job: 1..4 output bytes, lowest byte first
	typedef struct packed {
		logic [31:0] data;
		logic [1:0]  cnt;   // number of bytes minus one
		logic        last;
		logic        err;
	} job_t;

endpackage

[rtl/core/x86ctu_front.sv]
// Front end: scan, capture, address conversion; one byte per cycle unless q_full.
module x86ctu_front import x86ctu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic        q_full,
	output logic        in_ready,
	output logic        push,
	output job_t        job
);

	logic [7:0]  marker_q;
	logic [31:0] count_q;
	logic        jcc_q;

	logic [31:0] pos_q;
	logic [31:0] conv_q;
	phase_t      phase_q;
	logic [1:0]  idx_q;
	logic [7:0]  held_q [3];

	phase_t      phase_d;
	logic [1:0]  idx_d;
	logic [31:0] conv_d;
	logic [31:0] pos_next;
	logic [31:0] conv_val;
	logic        accept;
	logic        emit;
	logic        held_we;
	logic [1:0]  held_wi;
	logic        is_call;
	logic        is_jcc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pos_next = pos_q + 32'd1;
	assign is_call  = (in_byte == OP_CALL) || (in_byte == OP_JMP);
	assign is_jcc   = in_byte inside {[OP_JCC_LO:OP_JCC_HI]};
	assign conv_val = {8'h00, held_q[1], held_q[2], in_byte} - pos_next;

	// next state
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		conv_d  = conv_q;
		case (phase_q)
			PH_CAPTURE: begin
				if (idx_q == 2'd3) begin
					conv_d  = (conv_q != 32'd0) ? conv_q - 32'd1 : conv_q;
					phase_d = PH_SCAN;
					idx_d   = 2'd0;
				end else if (!in_last) begin
					idx_d = idx_q + 2'd1;
				end
			end
			default: begin
				if (conv_q == 32'd0) begin
					phase_d = PH_SCAN;
				end else if (phase_q == PH_AWAIT && in_byte == marker_q) begin
					if (!in_last) begin
						phase_d = PH_CAPTURE;
						idx_d   = 2'd1;
					end
				end else if (phase_q == PH_PREFIX) begin
					if (in_byte == OP_PREFIX)
						phase_d = PH_PREFIX;
					else if (is_jcc || is_call)
						phase_d = PH_AWAIT;
					else
						phase_d = PH_SCAN;
				end else begin
					if (jcc_q && in_byte == OP_PREFIX)
						phase_d = PH_PREFIX;
					else if (is_call)
						phase_d = PH_AWAIT;
					else
						phase_d = PH_SCAN;
				end
			end
		endcase
	end

	// outputs: job contents and held byte writes
	always_comb begin
		emit     = 1'b1;
		held_we  = 1'b0;
		held_wi  = 2'd0;
		job.data = {24'h000000, in_byte};
		job.cnt  = 2'd0;
		case (phase_q)
			PH_CAPTURE: begin
				if (idx_q == 2'd3) begin
					job.data = conv_val;
					job.cnt  = 2'd3;
				end else if (in_last) begin
					// incomplete capture: release held bytes unchanged
					if (idx_q == 2'd2) begin
						job.data = {8'h00, in_byte, held_q[1], held_q[0]};
						job.cnt  = 2'd2;
					end else begin
						job.data = {16'h0000, in_byte, held_q[0]};
						job.cnt  = 2'd1;
					end
				end else begin
					emit    = 1'b0;
					held_we = 1'b1;
					held_wi = idx_q;
				end
			end
			default: begin
				if (conv_q != 32'd0 && phase_q == PH_AWAIT && in_byte == marker_q
					&& !in_last) begin
					emit    = 1'b0;
					held_we = 1'b1;
					held_wi = 2'd0;
				end
			end
		endcase
		job.last = in_last;
		job.err  = in_last && ((conv_d != 32'd0) || (phase_d == PH_CAPTURE));
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= 8'h00;
			count_q  <= 32'd0;
			jcc_q    <= 1'b0;
			pos_q    <= 32'd0;
			conv_q   <= 32'd0;
			phase_q  <= PH_SCAN;
			idx_q    <= 2'd0;
		end else begin
			if (accept) begin
				if (in_last) begin
					pos_q   <= 32'd0;
					conv_q  <= count_q;
					phase_q <= PH_SCAN;
					idx_q   <= 2'd0;
				end else begin
					pos_q   <= pos_next;
					conv_q  <= conv_d;
					phase_q <= phase_d;
					idx_q   <= idx_d;
				end
			end else if (cfg_we && cfg_addr == REG_COUNT) begin
				conv_q <= cfg_wdata;
			end
			if (cfg_we) begin
				case (cfg_addr)
					REG_MARKER: marker_q <= cfg_wdata[7:0];
					REG_COUNT:  count_q  <= cfg_wdata;
					REG_JCC:    jcc_q    <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_we) begin
			case (held_wi)
				2'd0: held_q[0] <= in_byte;
				2'd1: held_q[1] <= in_byte;
				2'd2: held_q[2] <= in_byte;
				default: ;
			endcase
		end
	end

	a_idx_in_capture: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CAPTURE |-> idx_q != 2'd0)
		else $error("capture phase with empty capture index");
	a_idx_outside: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_CAPTURE |-> idx_q == 2'd0)
		else $error("capture index set outside capture");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> pos_q == 32'd0 && phase_q == PH_SCAN)
		else $error("stream state not restarted after last byte");

endmodule

[rtl/core/x86ctu_fifo.sv]
// Short job queue between front and back.
module x86ctu_fifo import x86ctu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wr_job,
	input  logic rd,
	output logic full,
	output logic not_empty,
	output job_t rd_job
);

	job_t               ent_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full      = cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_job    = ent_q[rp_q];
	assign do_wr     = wr && !full;
	assign do_rd     = rd && not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + 1'b1;
			if (do_rd)
				rp_q <= rp_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			ent_q[wp_q] <= wr_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full))
		else $error("job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && !not_empty))
		else $error("job popped from empty queue");

endmodule

[rtl/core/x86ctu_back.sv]
// Back end: serializes queued jobs into the output byte stream.
module x86ctu_back import x86ctu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  job_t       q_job,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_err
);

	job_t       cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       fin;
	logic       take;

	assign fin       = idx_q == cur_q.cnt;
	assign take      = busy_q && out_ready;
	assign q_pop     = q_valid && (!busy_q || (take && fin));
	assign out_valid = busy_q;
	assign out_byte  = cur_q.data[{idx_q, 3'b000} +: 8];
	assign out_last  = fin && cur_q.last;
	assign out_err   = fin && cur_q.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (take) begin
				if (fin)
					busy_q <= 1'b0;
				else
					idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_job;
	end

endmodule

[rtl/core/x86_call_target_unfilter_top.sv]
// Top level of the x86 call/jump target unfilter.
//
// Input stream s_axis: one byte per transaction, tlast on the final byte of a
// stream. Output stream m_axis: restored bytes, tlast on the final byte of the
// stream, tuser set on that byte when conversions remained or a capture of
// marker plus address bytes was cut off by the end of the stream.
// Config port: cfg_we writes cfg_wdata into register cfg_addr (0 marker byte,
// 1 conversion count, also reloading the remaining count, 2 jcc mode) in the
// same cycle; write only while the block is idle.
// Throughput: one input byte per cycle while the queue has room. The front end
// decides each byte in the accepting cycle (compares, the 32-bit address
// subtract and the count decrement) and posts a job of 1..4 bytes into a
// 4-entry queue; the back end sends one byte per cycle while m_axis_tready is
// high. A marker and two address bytes post nothing; the third address byte
// posts all four converted bytes, so output keeps pace with input. Each job
// goes through a queue entry and the back end's job register to the output.
// Stall: when m_axis_tready is low the back end holds its byte, the queue
// fills and s_axis_tready drops once four jobs wait.
// Reset: clears registers, position, scan state and queue; no clearing pass.
module x86_call_target_unfilter_top import x86ctu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // end_of_stream
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast,   // out_last
	output logic        m_axis_tuser    // [0] error
);

	logic push;
	logic q_full;
	logic q_ne;
	logic q_pop;
	job_t f_job;
	job_t q_job;

	x86ctu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.job       (f_job)
	);

	x86ctu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (push),
		.wr_job    (f_job),
		.rd        (q_pop),
		.full      (q_full),
		.not_empty (q_ne),
		.rd_job    (q_job)
	);

	x86ctu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_ne),
		.q_job     (q_job),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_err   (m_axis_tuser)
	);

endmodule

[bench/tb_top.sv]
// Self-checking bench for the x86 call/jump target unfilter: directed and random byte streams.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import x86ctu_pkg::*;

	// cycles allowed after the last expected byte before the block counts as quiet
	localparam int DRAIN_CYCLES = 8;
	// cycles without any transaction or register write before the run is abandoned
	localparam int STUCK_LIMIT  = 1000;
	// random bytes to send after the directed streams
	localparam int RANDOM_BYTES = 200;
	// index that decodes to no register; writes to it must be dropped
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       drain;   // hold this byte back until every expected byte is out
	} in_item_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       err;
	} out_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;  // end_of_stream
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;         // [7:0] out_byte
	logic        m_axis_tlast;         // out_last
	logic        m_axis_tuser;         // [0] error

	x86_call_target_unfilter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: register copies plus the per-stream scan state.
	// Registers only change while the block is quiet, so updating these
	// copies at write time keeps them in step with the hardware.
	// ------------------------------------------------------------------
	logic [7:0]  unf_marker = '0;
	logic [31:0] unf_count  = '0;
	logic        unf_jcc    = 1'b0;
	logic [31:0] unf_pos    = '0;
	logic [31:0] unf_left   = '0;
	phase_t      unf_phase  = PH_SCAN;
	int          unf_cap    = 0;
	logic [7:0]  unf_held [3];

	in_item_t    byte_q [$];      // bytes waiting to go out on s_axis
	out_item_t   restored_q [$];  // restored bytes the block still owes
	logic [7:0]  seq_buf [$];     // stream under construction
	logic        drain_next = 1'b0;

	int queued_n = 0;
	int accepted_n = 0;
	int checked_n = 0;
	int fail_count = 0;
	int n_conversions = 0;
	int n_streams = 0;
	int n_err_ends = 0;

	// Works out the restored bytes for one accepted input byte.
	task automatic unfilter_byte(input logic [7:0] x, input logic eos);
		logic [7:0]  ob [4];
		logic [31:0] addr;
		logic [31:0] rel;
		logic        err;
		out_item_t   o;
		int          n;
		n = 0;
		unf_pos = unf_pos + 32'd1;
		if (unf_phase == PH_CAPTURE) begin
			if (unf_cap >= 3) begin
				// third address byte: swap absolute target for relative one
				addr = {8'h00, unf_held[1], unf_held[2], x};
				rel = addr - unf_pos;
				ob[0] = rel[7:0];
				ob[1] = rel[15:8];
				ob[2] = rel[23:16];
				ob[3] = rel[31:24];
				n = 4;
				if (unf_left != 0)
					unf_left = unf_left - 32'd1;
				unf_phase = PH_SCAN;
				unf_cap = 0;
				n_conversions++;
			end else if (eos) begin
				// stream cut mid-capture: flush held bytes untouched
				for (int i = 0; i < unf_cap; i++) begin
					ob[n] = unf_held[i];
					n++;
				end
				ob[n] = x;
				n++;
			end else begin
				unf_held[unf_cap] = x;
				unf_cap++;
			end
		end else if (unf_left == 0) begin
			unf_phase = PH_SCAN;
			ob[0] = x;
			n = 1;
		end else if (unf_phase == PH_AWAIT && x == unf_marker) begin
			if (eos) begin
				ob[0] = x;
				n = 1;
			end else begin
				unf_held[0] = x;
				unf_cap = 1;
				unf_phase = PH_CAPTURE;
			end
		end else begin
			if (unf_phase == PH_PREFIX) begin
				if (x == OP_PREFIX)
					unf_phase = PH_PREFIX;
				else if ((x >= OP_JCC_LO && x <= OP_JCC_HI) || x == OP_CALL || x == OP_JMP)
					unf_phase = PH_AWAIT;
				else
					unf_phase = PH_SCAN;
			end else begin
				// scan, or await with a non-marker byte: rescan as an opcode
				if (unf_jcc && x == OP_PREFIX)
					unf_phase = PH_PREFIX;
				else if (x == OP_CALL || x == OP_JMP)
					unf_phase = PH_AWAIT;
				else
					unf_phase = PH_SCAN;
			end
			ob[0] = x;
			n = 1;
		end

		err = eos && (unf_left != 0 || unf_phase == PH_CAPTURE);
		for (int i = 0; i < n; i++) begin
			o.data = ob[i];
			o.last = eos && (i == n - 1);
			o.err = err && (i == n - 1);
			restored_q.push_back(o);
		end

		if (eos) begin
			n_streams++;
			if (err)
				n_err_ends++;
			unf_pos = '0;
			unf_left = unf_count;
			unf_phase = PH_SCAN;
			unf_cap = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		if (fail_count <= 20)
			$display("%0t ns: %s mismatch at output byte %0d: got %0h, expected %0h",
				$time, what, checked_n, got, want);
	endtask

	// Per-transaction random wait, with occasional bursts of back-to-back traffic.
	function automatic int pick_wait(ref int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0)
			quiet = $urandom_range(10, 40);
		return $urandom_range(0, 14);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents bytes from byte_q, predicts at acceptance.
	// ------------------------------------------------------------------
	in_item_t tx_cur;
	int       tx_wait = 0;
	int       tx_quiet = 0;
	logic     tx_holding;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			tx_wait = 0;
		end else begin
			tx_holding = s_axis_tvalid && !s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				unfilter_byte(tx_cur.data, tx_cur.last);
				accepted_n++;
				tx_wait = pick_wait(tx_quiet);
			end
			if (!tx_holding) begin
				if (tx_wait > 0) begin
					tx_wait--;
					s_axis_tvalid <= 1'b0;
				end else if (byte_q.size() != 0 &&
						!(byte_q[0].drain && restored_q.size() != 0)) begin
					tx_cur = byte_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= tx_cur.data;
					s_axis_tlast <= tx_cur.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each output transaction against the oldest
	// expectation, then stalls tready for a random number of cycles.
	// ------------------------------------------------------------------
	out_item_t rx_want;
	int        rx_wait = 0;
	int        rx_quiet = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (restored_q.size() == 0) begin
					report_mismatch("unexpected byte", {24'h0, m_axis_tdata}, '0);
				end else begin
					rx_want = restored_q.pop_front();
					if (m_axis_tdata !== rx_want.data)
						report_mismatch("out_byte", {24'h0, m_axis_tdata}, {24'h0, rx_want.data});
					if (m_axis_tlast !== rx_want.last)
						report_mismatch("out_last", {31'h0, m_axis_tlast}, {31'h0, rx_want.last});
					if (m_axis_tuser !== rx_want.err)
						report_mismatch("error", {31'h0, m_axis_tuser}, {31'h0, rx_want.err});
				end
				checked_n++;
				rx_wait = pick_wait(rx_quiet);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: any transaction or register write keeps the run alive.
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", STUCK_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_MARKER: unf_marker = val[7:0];
			REG_COUNT: begin
				unf_count = val;
				unf_left = val;   // count write also reloads the remaining count
			end
			REG_JCC: unf_jcc = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] marker, input logic [31:0] count,
			input logic jcc);
		cfg_write(REG_MARKER, {24'h0, marker});
		cfg_write(REG_COUNT, count);
		cfg_write(REG_JCC, {31'h0, jcc});
	endtask

	// Moves seq_buf onto the send queue; tlast on its final byte when eos.
	task automatic flush_seq(input logic eos);
		in_item_t it;
		foreach (seq_buf[k]) begin
			it.data = seq_buf[k];
			it.last = eos && (k == seq_buf.size() - 1);
			it.drain = drain_next;
			drain_next = 1'b0;
			byte_q.push_back(it);
			queued_n++;
		end
		seq_buf.delete();
	endtask

	// Block is quiet once every byte is in, every expected byte is out and
	// the pipeline had time to show anything stray.
	task automatic wait_idle();
		while (accepted_n != queued_n || restored_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A branch opcode: E8/E9, or with jcc mode a 0F chain ending in 80..8F, E8 or E9.
	task automatic add_opcode();
		int pick;
		pick = $urandom_range(0, 3);
		if (unf_jcc && pick >= 2) begin
			repeat ($urandom_range(1, 3)) seq_buf.push_back(OP_PREFIX);
			if (pick == 2)
				seq_buf.push_back(8'(OP_JCC_LO + $urandom_range(0, 15)));
			else
				seq_buf.push_back($urandom_range(0, 1) ? OP_CALL : OP_JMP);
		end else begin
			seq_buf.push_back(pick[0] ? OP_CALL : OP_JMP);
		end
	endtask

	// Mostly well-formed branch+marker+address runs, some noise and broken
	// opcodes; the stream may end anywhere inside a capture.
	task automatic add_random_stream();
		int kind;
		int tail;
		repeat ($urandom_range(1, 8)) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				add_opcode();
				seq_buf.push_back(unf_marker);
				repeat (3) seq_buf.push_back(8'($urandom));
			end else if (kind < 8) begin
				repeat ($urandom_range(1, 4)) seq_buf.push_back(8'($urandom));
			end else begin
				add_opcode();
				seq_buf.push_back(8'($urandom));
			end
		end
		tail = $urandom_range(0, 5);
		if (tail == 0 || tail == 5) begin
			seq_buf.push_back(8'($urandom));
		end else begin
			add_opcode();
			seq_buf.push_back(unf_marker);
			repeat (tail - 1) seq_buf.push_back(8'($urandom));
		end
		flush_seq(1'b1);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int          dir_n;
		int          streams;
		logic [7:0]  r_marker;
		logic [31:0] r_count;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain calls, marker 00: one conversion, then a jump whose next byte
		// is not the marker and is rescanned as a call; the second conversion
		// ends the stream with count used up and an all-ones address.
		// The dead register index gets an all-ones write that must do nothing.
		set_config(8'h00, 32'd2, 1'b0);
		cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
		seq_buf = '{OP_CALL, 8'h00, 8'h12, 8'h34, 8'h56};
		flush_seq(1'b0);
		drain_next = 1'b1;
		seq_buf = '{OP_JMP, OP_CALL, 8'h00, 8'hFF, 8'hFF, 8'hFF};
		flush_seq(1'b1);
		wait_idle();

		// Marker FF, huge count, jcc on: stream ending on the marker, broken
		// 0F chain (90 just past the jcc range), 0F 0F 8F chain cut off
		// mid-capture by end of stream.
		set_config(8'hFF, 32'hFFFF_FFFF, 1'b1);
		seq_buf = '{OP_CALL, 8'hFF};
		flush_seq(1'b1);
		seq_buf = '{OP_PREFIX, 8'h90, OP_PREFIX, OP_PREFIX, OP_JCC_HI, 8'hFF, 8'h01};
		flush_seq(1'b1);
		wait_idle();

		// Count cleared while a capture is half done: capture still completes,
		// later calls pass through, no error at the end.
		set_config(8'hFF, 32'd5, 1'b0);
		seq_buf = '{OP_CALL, 8'hFF, 8'h10};
		flush_seq(1'b0);
		wait_idle();
		cfg_write(REG_COUNT, 32'd0);
		seq_buf = '{8'h20, 8'h30, OP_CALL, 8'hFF, 8'h07};
		flush_seq(1'b1);
		wait_idle();

		// Random phases, each under its own register setting.
		dir_n = queued_n;
		while (queued_n - dir_n < RANDOM_BYTES) begin
			case ($urandom_range(0, 3))
				0: r_marker = 8'h00;
				1: r_marker = 8'hFF;
				2: r_marker = OP_CALL;
				default: r_marker = 8'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: r_count = 32'd0;
				1: r_count = 32'd1;
				2: r_count = 32'hFFFF_FFFF;
				3: r_count = $urandom;
				default: r_count = $urandom_range(2, 6);
			endcase
			set_config(r_marker, r_count, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) == 0)
				cfg_write(REG_UNUSED, $urandom);
			streams = $urandom_range(1, 3);
			for (int s = 0; s < streams; s++) begin
				if (s == 1 && $urandom_range(0, 1) == 1)
					drain_next = 1'b1;
				add_random_stream();
			end
			wait_idle();
		end

		if (restored_q.size() != 0)
			report_mismatch("missing bytes", restored_q.size(), 0);

		$display("Sent %0d bytes in %0d streams, checked %0d restored bytes.",
			accepted_n, n_streams, checked_n);
		$display("Covered %0d address conversions and %0d streams ending with error set.",
			n_conversions, n_err_ends);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/x86ctu_pkg.sv
rtl/core/x86ctu_front.sv
rtl/core/x86ctu_fifo.sv
rtl/core/x86ctu_back.sv
rtl/core/x86_call_target_unfilter_top.sv
bench/tb_top.sv
